### hdl/nm3_pkg.sv
// Shared constants, types and helpers of the 3x3 neighbourhood mean block.
package nm3_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int VALUE_BITS = 16;

  localparam int DIM_BITS       = 11;
  localparam int POS_BITS       = 10;
  localparam int MEAN_BITS      = 24;
  localparam int CFG_INDEX_BITS = 1;

  localparam int COL_BITS     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_CNT_BITS = $clog2(MAX_ROWS + 2);

  localparam int CNT_BITS  = 4;
  localparam int DVS_BITS  = CNT_BITS + 1;
  localparam int SUM_BITS  = VALUE_BITS + 4;
  localparam int MAG_BITS  = VALUE_BITS + 3;
  localparam int FRAC_BITS = 8;
  localparam int NUM_BITS  = MAG_BITS + FRAC_BITS + 1;
  localparam int DIGITS    = (NUM_BITS + 3) / 4;
  localparam int NUM_PAD   = DIGITS * 4;
  localparam int STEP_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLS = 1'b1;

  typedef logic signed [VALUE_BITS-1:0] pix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0]        count;
  } div_req_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] maxv);
    logic [DIM_BITS-1:0] res;
    if (v == '0) begin
      res = DIM_BITS'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### hdl/nm3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module nm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/nm3_div.sv
// Radix-16 restoring divider that turns a window sum and cell count into a rounded mean.
module nm3_div
  import nm3_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  div_req_t                    req,
  output logic                        done,
  output logic signed [MEAN_BITS-1:0] mean
);

  localparam int T_BITS = DVS_BITS + 4;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [DVS_BITS-1:0]  rem_r, rem_nxt;
  logic [DVS_BITS-1:0]  dvs_r, dvs_nxt;
  logic [NUM_PAD-1:0]   num_r, num_nxt;
  logic [MEAN_BITS-1:0] quo_r, quo_nxt;
  logic                 neg_r, neg_nxt;

  logic                 start_neg;
  logic [SUM_BITS-1:0]  abs_sum;
  logic [NUM_BITS-1:0]  start_num;
  logic [T_BITS-1:0]    part;
  logic [3:0]           qd;

  always_comb begin
    start_neg = req.sum[SUM_BITS-1];
    abs_sum   = start_neg ? (~req.sum + 1'b1) : req.sum;
    start_num = {abs_sum[MAG_BITS-1:0], {(FRAC_BITS + 1 - CNT_BITS){1'b0}}, req.count};
  end

  always_comb begin
    part = {rem_r, num_r[NUM_PAD-1 -: 4]};
    qd   = '0;
    for (int b = 3; b >= 0; b--) begin
      if (part >= (T_BITS'(dvs_r) << b)) begin
        part  = part - (T_BITS'(dvs_r) << b);
        qd[b] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvs_nxt  = {req.count, 1'b0};
      num_nxt  = NUM_PAD'(start_num);
      quo_nxt  = '0;
      neg_nxt  = start_neg;
    end else if (busy_r) begin
      rem_nxt  = part[DVS_BITS-1:0];
      num_nxt  = {num_r[NUM_PAD-5:0], 4'b0000};
      quo_nxt  = {quo_r[MEAN_BITS-5:0], qd};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_BITS'(DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
  end

  assign done = done_r;
  assign mean = neg_r ? $signed(~quo_r + 1'b1) : $signed(quo_r);

endmodule

### hdl/neighbourhood_mean_3x3_core.sv
// Top level of the streaming 3x3 border-clipped neighbourhood mean.
// Values arrive in raster order and each cell's mean (8 fraction bits, rounded half away from
// zero, window clipped at every border) leaves one row plus one cell later; after the last
// value, drain requests push out the remaining means. A write to grid_rows or grid_cols
// restarts the frame. Two line stores in synchronous RAM are read and rotated once per counted
// request, with the column window in registers. A drain that arrives before the frame is full
// is taken and dropped, a request that yields no mean passes a line-store read and write-back,
// and a request that yields a mean also passes the window sum and the radix-16 divider's 7 digit
// steps; the output register lets the next request in while a mean waits to be taken.
module neighbourhood_mean_3x3_core
  import nm3_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic signed [VALUE_BITS-1:0] in_cell_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [MEAN_BITS-1:0] out_mean_value,
  output logic [POS_BITS-1:0]         out_row,
  output logic [POS_BITS-1:0]         out_col,
  output logic                        out_frame_last,
  input  logic                        cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [DIM_BITS-1:0]         cfg_data
);

  state_t state_r, state_nxt;

  logic [DIM_BITS-1:0]     rows_r, cols_r;
  logic [ROW_CNT_BITS-1:0] in_row_r, in_row_nxt;
  logic [COL_BITS-1:0]     in_col_r, in_col_nxt;
  pix_t                    val_r;

  pix_t                    win_r [3][3];
  pix_t                    win_nxt [3][3];
  pix_t                    pick [3][3];
  pix_t                    sel_r [3][3];
  pix_t                    sel_nxt [3][3];
  logic [CNT_BITS-1:0]     count_r, count_nxt;
  logic [ROW_CNT_BITS-1:0] res_row;
  logic [DIM_BITS-1:0]     res_col;
  logic [POS_BITS-1:0]     res_row_r, res_col_r;
  logic                    last_r;

  logic                    out_valid_r;
  logic signed [MEAN_BITS-1:0] out_mean_r;
  logic [POS_BITS-1:0]     out_row_r, out_col_r;
  logic                    out_last_r;

  logic [VALUE_BITS-1:0]   la1_rd, la2_rd;
  logic                    ignore_req, accept, take, mem_we, div_start, load_out, out_free;
  logic                    produce, frame_end;
  logic                    top_ok, bot_ok, left_ok, right_ok;
  logic [1:0]              rcnt, ccnt;
  logic [2:0]              row_ok, col_ok;
  logic signed [SUM_BITS-1:0] acc;
  div_req_t                div_req;
  logic                    div_done;
  logic signed [MEAN_BITS-1:0] div_mean;

  assign ignore_req = (in_command == CMD_DRAIN) && ({1'b0, in_row_r} < {1'b0, rows_r});
  assign out_free   = !out_valid_r || !out_stall;
  assign produce    = (in_row_r >= ROW_CNT_BITS'(2)) ||
                      ((in_row_r == ROW_CNT_BITS'(1)) && (in_col_r != '0));
  assign frame_end  = ({1'b0, in_row_r} == ({1'b0, rows_r} + 1'b1)) && (in_col_r == '0);

  nm3_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_above (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (in_col_r),
    .wr_data (val_r),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .rd_data (la1_rd)
  );

  nm3_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_two_above (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (in_col_r),
    .wr_data (la1_rd),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .rd_data (la2_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !ignore_req) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = produce ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_READ: mem_we = 1'b1;
      ST_SUM:  div_start = 1'b1;
      ST_DIV:  load_out = div_done && out_free;
      ST_HOLD: load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign take   = accept && !ignore_req;

  // Column vector entering the window: row above-above, row above, current row.
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      win_nxt[0][t] = win_r[1][t];
      win_nxt[1][t] = win_r[2][t];
    end
    win_nxt[2][0] = la2_rd;
    win_nxt[2][1] = la1_rd;
    win_nxt[2][2] = val_r;

    if (in_col_r != '0) begin
      pick    = win_nxt;
      res_row = in_row_r - 1'b1;
      res_col = {1'b0, in_col_r} - 1'b1;
    end else begin
      for (int t = 0; t < 3; t++) begin
        pick[0][t] = win_r[1][t];
        pick[1][t] = win_r[2][t];
        pick[2][t] = '0;
      end
      res_row = in_row_r - ROW_CNT_BITS'(2);
      res_col = cols_r - 1'b1;
    end

    top_ok   = res_row != '0;
    bot_ok   = ({1'b0, res_row} + 1'b1) < {1'b0, rows_r};
    left_ok  = res_col != '0;
    right_ok = (res_col + 1'b1) < cols_r;
    row_ok   = {bot_ok, 1'b1, top_ok};
    col_ok   = {right_ok, 1'b1, left_ok};
    rcnt     = 2'd1 + 2'(top_ok) + 2'(bot_ok);
    ccnt     = 2'd1 + 2'(left_ok) + 2'(right_ok);
    count_nxt = CNT_BITS'(rcnt) * CNT_BITS'(ccnt);

    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 3; t++) begin
        sel_nxt[k][t] = (col_ok[k] && row_ok[t]) ? pick[k][t] : '0;
      end
    end
  end

  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (frame_end) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
    end else if (({1'b0, in_col_r} + 1'b1) == cols_r) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + 1'b1;
    end else begin
      in_col_nxt = in_col_r + 1'b1;
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 3; t++) begin
        acc = acc + {{(SUM_BITS - VALUE_BITS){sel_r[k][t][VALUE_BITS-1]}}, sel_r[k][t]};
      end
    end
    div_req.sum   = acc;
    div_req.count = count_r;
  end

  nm3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .mean  (div_mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= DIM_BITS'(1);
      cols_r      <= DIM_BITS'(1);
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_GRID_ROWS: rows_r <= clamp_dim(cfg_data, DIM_BITS'(MAX_ROWS));
          REG_GRID_COLS: cols_r <= clamp_dim(cfg_data, DIM_BITS'(MAX_COLS));
        endcase
        in_row_r <= '0;
        in_col_r <= '0;
      end else if (mem_we) begin
        in_row_r <= in_row_nxt;
        in_col_r <= in_col_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      val_r <= in_cell_value;
    end
    if (mem_we) begin
      win_r <= win_nxt;
      if (produce) begin
        sel_r     <= sel_nxt;
        count_r   <= count_nxt;
        res_row_r <= POS_BITS'(res_row);
        res_col_r <= POS_BITS'(res_col);
        last_r    <= frame_end;
      end
    end
    if (load_out) begin
      out_mean_r <= div_mean;
      out_row_r  <= res_row_r;
      out_col_r  <= res_col_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

endmodule

### hdl/nm3_checker.sv
// Port-level checks of the 3x3 neighbourhood mean core, bound to its top level.
module nm3_checker
  import nm3_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [MEAN_BITS-1:0] out_mean_value,
  input logic [POS_BITS-1:0]         out_row,
  input logic [POS_BITS-1:0]         out_col,
  input logic                        out_frame_last,
  input logic                        cfg_wr_en,
  input logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input logic [DIM_BITS-1:0]         cfg_data
);

  logic [DIM_BITS-1:0] rows_r, cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_BITS'(1);
      cols_r <= DIM_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_ROWS: rows_r <= clamp_dim(cfg_data, DIM_BITS'(MAX_ROWS));
        REG_GRID_COLS: cols_r <= clamp_dim(cfg_data, DIM_BITS'(MAX_COLS));
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean_value) && $stable(out_row) &&
      $stable(out_col) && $stable(out_frame_last))
    else $error("result changed or dropped while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_row} < rows_r) && ({1'b0, out_col} < cols_r))
    else $error("result position outside the grid");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |->
      ({1'b0, out_row} == rows_r - 1'b1) && ({1'b0, out_col} == cols_r - 1'b1))
    else $error("frame_last not on the final cell");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared straight after a request");

endmodule

bind neighbourhood_mean_3x3_core nm3_checker u_nm3_checker (.*);

### verif/tb_top.sv
// Testbench for the 3x3 neighbourhood mean core: raster requests checked against a predictor.
module tb_top;
  import nm3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_REQS    = 450;
  localparam int MAX_PRINTS     = 100;

  typedef struct {
    logic cmd;
    pix_t value;
  } pixel_req_t;

  typedef struct {
    logic signed [MEAN_BITS-1:0] mean;
    logic [POS_BITS-1:0]         row;
    logic [POS_BITS-1:0]         col;
    logic                        last;
  } mean_rec_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_command = CMD_PIXEL;
  logic signed [VALUE_BITS-1:0] in_cell_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [MEAN_BITS-1:0]  out_mean_value;
  logic [POS_BITS-1:0]          out_row;
  logic [POS_BITS-1:0]          out_col;
  logic                         out_frame_last;
  logic                         cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = REG_GRID_ROWS;
  logic [DIM_BITS-1:0]          cfg_data = '0;

  pixel_req_t pending_reqs[$];
  mean_rec_t  means_due[$];
  pixel_req_t tx_req;
  mean_rec_t  due_rec;

  // predictor state
  pix_t                row_bank [3][MAX_COLS];
  logic [DIM_BITS-1:0] grid_rows_q = DIM_BITS'(1);
  logic [DIM_BITS-1:0] grid_cols_q = DIM_BITS'(1);
  int unsigned         wr_row;
  int unsigned         wr_col;
  int unsigned         frame_count;

  int  err_count;
  int  tx_gap;
  int  tx_quiet;
  int  rx_gap;
  int  rx_quiet;
  int  hold_left;
  bit  hold_go;
  bit  hold_done;
  int  idle_cycles;
  int  reqs_sent;
  logic [DIM_BITS-1:0] rows_raw;
  logic [DIM_BITS-1:0] cols_raw;

  neighbourhood_mean_3x3_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mean_value(out_mean_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_last(out_frame_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned dim_clip(input logic [DIM_BITS-1:0] v, input int unsigned maxv);
    int unsigned d;
    d = v;
    if (d < 1) d = 1;
    if (d > maxv) d = maxv;
    return d;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pix_t rand_value();
    pix_t v;
    case ($urandom_range(0, 9))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = pix_t'($urandom_range(0, 1) ? -1 : 0);
      default: v = pix_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string what);
    if (err_count < MAX_PRINTS) $display("tb_top: mismatch: %s", what);
    err_count++;
  endtask

  task automatic predict_mean(input logic cmd, input pix_t val);
    int unsigned rows, cols, total, n, p, r, c, r0, r1, c0, c1, rr, cc;
    bit stores, neg;
    longint sum, incoming, mean_l;
    longint unsigned mag, q, cnt;
    mean_rec_t rec;
    rows = dim_clip(grid_rows_q, MAX_ROWS);
    cols = dim_clip(grid_cols_q, MAX_COLS);
    total = rows * cols;
    n = frame_count;
    stores = 1'b0;
    incoming = 0;
    if (n < total) begin
      if (cmd == CMD_DRAIN) return;
      stores = 1'b1;
      incoming = longint'(val);
    end
    if (n >= cols + 1) begin
      p = n - (cols + 1);
      r = p / cols;
      c = p % cols;
      r0 = (r > 0) ? r - 1 : 0;
      r1 = (r + 1 < rows) ? r + 1 : rows - 1;
      c0 = (c > 0) ? c - 1 : 0;
      c1 = (c + 1 < cols) ? c + 1 : cols - 1;
      sum = 0;
      cnt = 0;
      for (rr = r0; rr <= r1; rr++) begin
        for (cc = c0; cc <= c1; cc++) begin
          if (stores && rr * cols + cc == n) sum += incoming;
          else sum += longint'(row_bank[rr % 3][cc]);
          cnt++;
        end
      end
      neg = (sum < 0);
      mag = neg ? longint'(-sum) : longint'(sum);
      q = (2 * mag * 256 + cnt) / (2 * cnt);
      if (q > 64'd8388608) q = 64'd8388608;
      mean_l = neg ? -longint'(q) : longint'(q);
      if (mean_l > 64'sd8388607) mean_l = 64'sd8388607;
      if (mean_l < -64'sd8388608) mean_l = -64'sd8388608;
      rec.mean = mean_l[MEAN_BITS-1:0];
      rec.row = r[POS_BITS-1:0];
      rec.col = c[POS_BITS-1:0];
      rec.last = (p + 1 == total);
      means_due.push_back(rec);
    end
    if (stores) begin
      row_bank[wr_row % 3][wr_col] = val;
      wr_col++;
      if (wr_col >= cols) begin
        wr_col = 0;
        wr_row++;
      end
    end
    frame_count = n + 1;
    if (frame_count >= total + cols + 1) begin
      wr_row = 0;
      wr_col = 0;
      frame_count = 0;
    end
  endtask

  task automatic push_req(input logic cmd, input pix_t val);
    pixel_req_t req;
    req.cmd = cmd;
    req.value = val;
    pending_reqs.push_back(req);
    reqs_sent++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || means_due.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_grid(input logic [CFG_INDEX_BITS-1:0] idx, input logic [DIM_BITS-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == REG_GRID_ROWS) grid_rows_q = v;
    else grid_cols_q = v;
    wr_row = 0;
    wr_col = 0;
    frame_count = 0;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // full frame with noise: early drains, values in the closing run, a stray drain after the end
  task automatic push_frame(input logic [DIM_BITS-1:0] rr, input logic [DIM_BITS-1:0] cr);
    int unsigned rows, cols, i;
    rows = dim_clip(rr, MAX_ROWS);
    cols = dim_clip(cr, MAX_COLS);
    for (i = 0; i < rows * cols; i++) begin
      if ($urandom_range(0, 19) == 0) push_req(CMD_DRAIN, rand_value());
      push_req(CMD_PIXEL, rand_value());
    end
    for (i = 0; i < cols + 1; i++) begin
      if ($urandom_range(0, 3) == 0) push_req(CMD_PIXEL, rand_value());
      else push_req(CMD_DRAIN, rand_value());
    end
    if ($urandom_range(0, 4) == 0) push_req(CMD_DRAIN, rand_value());
  endtask

  function automatic logic [DIM_BITS-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DIM_BITS'($urandom_range(7, 12));
      2: return DIM_BITS'(1);
      default: return DIM_BITS'($urandom_range(2, 6));
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
      tx_quiet = 0;
    end else begin
      if (in_valid && !in_stall) predict_mean(in_command, in_cell_value);
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          tx_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_command <= tx_req.cmd;
          in_cell_value <= tx_req.value;
          if (tx_quiet > 0) begin
            tx_quiet--;
            tx_gap = 0;
          end else begin
            if ($urandom_range(0, 49) == 0) tx_quiet = $urandom_range(30, 150);
            tx_gap = gap_len();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off once requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap = 0;
      rx_quiet = 0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (rx_quiet > 0) begin
        rx_quiet--;
      end else begin
        if ($urandom_range(0, 49) == 0) rx_quiet = $urandom_range(30, 150);
        rx_gap = gap_len();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (means_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected mean %0d at row %0d col %0d",
                                out_mean_value, out_row, out_col));
      end else begin
        due_rec = means_due.pop_front();
        if (out_mean_value !== due_rec.mean || out_row !== due_rec.row ||
            out_col !== due_rec.col || out_frame_last !== due_rec.last) begin
          flag_mismatch($sformatf({"got r%0d c%0d mean %0d last %0b, ",
                                   "want r%0d c%0d mean %0d last %0b"},
                                  out_row, out_col, out_mean_value, out_frame_last,
                                  due_rec.row, due_rec.col, due_rec.mean, due_rec.last));
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int unsigned k, i, rows, cols;
    err_count = 0;
    reqs_sent = 0;
    hold_go = 1'b0;
    hold_done = 1'b0;
    wr_row = 0;
    wr_col = 0;
    frame_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size 1x1: early drain dropped, then a lone maximum value
    push_req(CMD_DRAIN, 16'sh7fff);
    push_req(CMD_PIXEL, 16'sh7fff);
    push_req(CMD_DRAIN, 16'sh0000);
    push_req(CMD_DRAIN, 16'sh0000);
    push_req(CMD_DRAIN, 16'sh8000);

    // zero rows acts as one: single row of minimum values, value in the closing run
    write_grid(REG_GRID_ROWS, '0);
    write_grid(REG_GRID_COLS, DIM_BITS'(3));
    repeat (3) push_req(CMD_PIXEL, 16'sh8000);
    push_req(CMD_DRAIN, 16'sh0000);
    push_req(CMD_PIXEL, 16'sh1234);
    push_req(CMD_DRAIN, 16'sh0000);
    push_req(CMD_DRAIN, 16'sh0000);

    // single column
    write_grid(REG_GRID_ROWS, DIM_BITS'(3));
    write_grid(REG_GRID_COLS, '0);
    push_req(CMD_PIXEL, 16'sh7fff);
    push_req(CMD_PIXEL, -16'sd1);
    push_req(CMD_PIXEL, 16'sh0000);
    push_req(CMD_DRAIN, 16'sh0000);
    push_req(CMD_DRAIN, 16'sh0000);

    // 3x3 with a drain in the middle of the frame
    write_grid(REG_GRID_COLS, DIM_BITS'(3));
    for (i = 0; i < 9; i++) begin
      if (i == 4) push_req(CMD_DRAIN, 16'sh5555);
      push_req(CMD_PIXEL, (i % 2) ? 16'sh7fff : 16'sh8000);
    end
    repeat (4) push_req(CMD_DRAIN, 16'shffff);

    // oversized row count clips to the maximum, cut short by a restart
    write_grid(REG_GRID_ROWS, DIM_BITS'(2047));
    write_grid(REG_GRID_COLS, DIM_BITS'(5));
    for (i = 0; i < 24; i++) push_req(CMD_PIXEL, rand_value());

    // full frame while the receiver is held off
    write_grid(REG_GRID_ROWS, DIM_BITS'(6));
    push_frame(DIM_BITS'(6), DIM_BITS'(5));
    hold_go = 1'b1;

    rows_raw = DIM_BITS'(4);
    cols_raw = DIM_BITS'(4);
    write_grid(REG_GRID_ROWS, rows_raw);
    write_grid(REG_GRID_COLS, cols_raw);

    while (reqs_sent < RANDOM_REQS) begin
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 1) == 1) begin
          rows_raw = pick_dim();
          write_grid(REG_GRID_ROWS, rows_raw);
        end
        if ($urandom_range(0, 2) != 0) begin
          cols_raw = pick_dim();
          write_grid(REG_GRID_COLS, cols_raw);
        end
      end
      rows = dim_clip(rows_raw, MAX_ROWS);
      cols = dim_clip(cols_raw, MAX_COLS);
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, rows * cols + cols);
        for (i = 0; i < k; i++) push_req((i < rows * cols) ? CMD_PIXEL : CMD_DRAIN, rand_value());
        write_grid(REG_GRID_ROWS, rows_raw);
      end else begin
        push_frame(rows_raw, cols_raw);
      end
    end

    wait_idle();
    repeat (30) @(negedge clk);
    if (err_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
